@@ rtl/cbct_pkg.sv @@
// Package: shared codes, state type and reset defaults for the blob centroid tracker.
package cbct_pkg;

    localparam int DEF_MAX_ENTRIES = 64;
    localparam int DEF_COORD_BITS  = 12;
    localparam int DEF_COUNT_BITS  = 24;

    localparam logic [7:0]  DEF_TARGET_RED   = 8'd210;
    localparam logic [7:0]  DEF_TARGET_GREEN = 8'd229;
    localparam logic [6:0]  DEF_SPREAD       = 7'd15;
    localparam logic [25:0] DEF_RADIUS_SQ    = 26'd2500;
    localparam logic [31:0] DEF_MAX_AGE      = 32'd300000;

    localparam logic [1:0] CMD_PIXEL = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [2:0] STAT_REJECT = 3'd0;
    localparam logic [2:0] STAT_JOIN   = 3'd1;
    localparam logic [2:0] STAT_NEW    = 3'd2;
    localparam logic [2:0] STAT_DROP   = 3'd3;
    localparam logic [2:0] STAT_DONE   = 3'd4;

    localparam logic [2:0] CFG_TARGET_RED   = 3'd0;
    localparam logic [2:0] CFG_TARGET_GREEN = 3'd1;
    localparam logic [2:0] CFG_SPREAD       = 3'd2;
    localparam logic [2:0] CFG_RADIUS_SQ    = 3'd3;
    localparam logic [2:0] CFG_MAX_AGE      = 3'd4;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DECIDE,
        FSM_MUL,
        FSM_DIV_LOAD,
        FSM_DIV_WAIT,
        FSM_COMMIT,
        FSM_RESP
    } fsm_state_t;

endpackage

@@ rtl/cbct_cell.sv @@
// One table slot of the rotating entry chain.
module cbct_cell
    import cbct_pkg::*;
#(
    parameter int PW = 80
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          shift_en,
    input  logic          valid_in,
    input  logic [PW-1:0] data_in,
    output logic          valid_out,
    output logic [PW-1:0] data_out
);

    logic          valid_reg;
    logic [PW-1:0] data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            data_reg <= data_in;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

@@ rtl/cbct_div.sv @@
// Restoring divider, one quotient bit per cycle, quotient known to fit QBITS.
module cbct_div
    import cbct_pkg::*;
#(
    parameter int QBITS = DEF_COORD_BITS,
    parameter int VBITS = DEF_COUNT_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [QBITS+VBITS-1:0] num,
    input  logic [VBITS:0]         den,
    output logic                   busy,
    output logic [QBITS-1:0]       quot
);

    localparam int CW = $clog2(QBITS + 1);

    logic           busy_reg;
    logic [CW-1:0]  cnt_reg;
    logic [VBITS:0] rem_reg;
    logic [VBITS:0] den_reg;
    logic [QBITS-1:0] low_reg;
    logic [QBITS-1:0] q_reg;
    logic [VBITS+1:0] trial;
    logic [VBITS+1:0] diff;
    logic             fits;

    assign trial = {rem_reg, low_reg[QBITS-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(QBITS);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {1'b0, num[QBITS+VBITS-1:QBITS]};
            low_reg <= num[QBITS-1:0];
            den_reg <= den;
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[VBITS:0] : trial[VBITS:0];
            low_reg <= {low_reg[QBITS-2:0], 1'b0};
            q_reg   <= {q_reg[QBITS-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

@@ rtl/color_blob_centroid_tracker_core.sv @@
// Top level: blob centroid tracker with a rotating chain of table slots.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  s_      | s_valid s_ready s_command s_red ...     | in
//  m_      | m_valid m_ready m_status m_slot ...     | out
//  cfg_    | cfg_valid cfg_ready cfg_index cfg_data  | in
//
// Rejected pixels and unknown commands go straight to the response state.
// Tick, clear, dropped pixel: one rotation of the slot chain.
// Joined pixel: search rotation, multiply, divider, commit rotation; new entry:
// search rotation and commit rotation.
// Synchronous active-low reset empties the table; no clearing pass is needed.
// A finished result waits in the output register while the next beat is taken.
module color_blob_centroid_tracker_core
    import cbct_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int COORD_BITS  = DEF_COORD_BITS,
    parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [11:0] s_pos_x,
    input  logic [11:0] s_pos_y,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [5:0]  m_slot,
    output logic [11:0] m_centre_x_out,
    output logic [11:0] m_centre_y_out,
    output logic [6:0]  m_removed,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int CB  = COORD_BITS;
    localparam int NB  = COUNT_BITS;
    localparam int IDW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RW  = $clog2(MAX_ENTRIES + 1);
    localparam int DW  = 2 * CB + 1;
    localparam int KW  = (DW > 26) ? DW : 26;

    typedef struct packed {
        logic [CB-1:0] cx;
        logic [CB-1:0] cy;
        logic [NB-1:0] n;
        logic [31:0]   birth;
    } entry_t;

    localparam int PW = $bits(entry_t);

    fsm_state_t state_reg, state_next;

    logic [7:0]  target_red_reg, target_green_reg;
    logic [6:0]  spread_reg;
    logic [25:0] radius_sq_reg;
    logic [31:0] max_age_reg;
    logic [31:0] fc_reg;

    logic [1:0]     op_reg;
    logic [CB-1:0]  x_reg, y_reg;
    logic [IDW-1:0] id_reg;
    logic [RW-1:0]  removed_reg;
    logic           match_reg, free_reg;
    logic [IDW-1:0] match_id_reg, free_id_reg;
    entry_t         match_e_reg;
    logic [CB+NB-1:0] prod_x_reg, prod_y_reg;

    logic [2:0]     res_status_reg;
    logic [IDW-1:0] res_slot_reg;
    logic [CB-1:0]  res_cx_reg, res_cy_reg;

    logic        m_valid_reg;
    logic [2:0]  m_status_reg;
    logic [5:0]  m_slot_reg;
    logic [11:0] m_cx_reg, m_cy_reg;
    logic [6:0]  m_removed_reg;

    logic          chain_valid [MAX_ENTRIES];
    logic [PW-1:0] chain_data  [MAX_ENTRIES];

    logic   shift_en, div_start, out_load, accept, pass_end;
    logic   in_window, div_busy_x, div_busy_y;
    logic   head_v, mod_v, rem_inc, near, expire;
    entry_t head_e, mod_e;
    logic [CB-1:0]   dx, dy, qx, qy;
    logic [2*CB-1:0] dx_sq, dy_sq;
    logic [DW-1:0]   dist_sq;
    logic [31:0]     age;
    logic [NB-1:0]   n_sat;
    logic [CB+NB-1:0] num_x, num_y;
    logic [NB:0]     den;
    logic [8:0]      r_hi, g_hi, tr_hi, tg_hi;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == FSM_IDLE);
    assign cfg_ready = 1'b1;
    assign pass_end  = (id_reg == '0);

    assign r_hi  = {1'b0, s_red} + {2'b0, spread_reg};
    assign g_hi  = {1'b0, s_green} + {2'b0, spread_reg};
    assign tr_hi = {1'b0, target_red_reg} + {2'b0, spread_reg};
    assign tg_hi = {1'b0, target_green_reg} + {2'b0, spread_reg};
    assign in_window = (r_hi >= {1'b0, target_red_reg}) && ({1'b0, s_red} <= tr_hi)
                    && (g_hi >= {1'b0, target_green_reg}) && ({1'b0, s_green} <= tg_hi);

    // slot chain
    for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_chain
        if (k == 0) begin : g_head
            cbct_cell #(.PW(PW)) u_cell (
                .aclk(aclk), .aresetn(aresetn), .shift_en(shift_en),
                .valid_in(mod_v), .data_in(mod_e),
                .valid_out(chain_valid[k]), .data_out(chain_data[k])
            );
        end else begin : g_body
            cbct_cell #(.PW(PW)) u_cell (
                .aclk(aclk), .aresetn(aresetn), .shift_en(shift_en),
                .valid_in(chain_valid[k-1]), .data_in(chain_data[k-1]),
                .valid_out(chain_valid[k]), .data_out(chain_data[k])
            );
        end
    end

    assign head_v = chain_valid[MAX_ENTRIES-1];
    assign head_e = entry_t'(chain_data[MAX_ENTRIES-1]);

    assign dx    = (head_e.cx >= x_reg) ? head_e.cx - x_reg : x_reg - head_e.cx;
    assign dy    = (head_e.cy >= y_reg) ? head_e.cy - y_reg : y_reg - head_e.cy;
    assign dx_sq = (2*CB)'(dx) * (2*CB)'(dx);
    assign dy_sq = (2*CB)'(dy) * (2*CB)'(dy);
    assign dist_sq = DW'(dx_sq) + DW'(dy_sq);
    assign near  = KW'(dist_sq) <= KW'(radius_sq_reg);
    assign age    = fc_reg - head_e.birth;
    assign expire = age > max_age_reg;

    assign n_sat = (match_e_reg.n == '1) ? match_e_reg.n : match_e_reg.n + 1'b1;
    assign num_x = prod_x_reg + (CB+NB)'(x_reg);
    assign num_y = prod_y_reg + (CB+NB)'(y_reg);
    assign den   = {1'b0, match_e_reg.n} + 1'b1;

    cbct_div #(.QBITS(CB), .VBITS(NB)) u_div_x (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(num_x), .den(den), .busy(div_busy_x), .quot(qx)
    );

    cbct_div #(.QBITS(CB), .VBITS(NB)) u_div_y (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(num_y), .den(den), .busy(div_busy_y), .quot(qy)
    );

    // head of chain: aging, clearing and commit rewrite
    always_comb begin
        mod_v   = head_v;
        mod_e   = head_e;
        rem_inc = 1'b0;
        if (state_reg == FSM_SCAN) begin
            if (op_reg == CMD_TICK && head_v && expire) begin
                mod_v   = 1'b0;
                rem_inc = 1'b1;
            end else if (op_reg == CMD_CLEAR) begin
                mod_v   = 1'b0;
                rem_inc = head_v;
            end
        end else if (state_reg == FSM_COMMIT && res_slot_reg == id_reg) begin
            mod_v = 1'b1;
            if (match_reg) begin
                mod_e.cx = qx;
                mod_e.cy = qy;
                mod_e.n  = n_sat;
            end else begin
                mod_e.cx    = x_reg;
                mod_e.cy    = y_reg;
                mod_e.n     = NB'(1);
                mod_e.birth = fc_reg;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE: begin
                if (accept) begin
                    if (s_command == CMD_TICK || s_command == CMD_CLEAR) begin
                        state_next = FSM_SCAN;
                    end else if (s_command == CMD_PIXEL && in_window) begin
                        state_next = FSM_SCAN;
                    end else begin
                        state_next = FSM_RESP;
                    end
                end
            end
            FSM_SCAN: begin
                if (pass_end) begin
                    state_next = FSM_DECIDE;
                end
            end
            FSM_DECIDE: begin
                if (op_reg != CMD_PIXEL) begin
                    state_next = FSM_RESP;
                end else if (match_reg) begin
                    state_next = FSM_MUL;
                end else if (free_reg) begin
                    state_next = FSM_COMMIT;
                end else begin
                    state_next = FSM_RESP;
                end
            end
            FSM_MUL:      state_next = FSM_DIV_LOAD;
            FSM_DIV_LOAD: state_next = FSM_DIV_WAIT;
            FSM_DIV_WAIT: begin
                if (!div_busy_x) begin
                    state_next = FSM_COMMIT;
                end
            end
            FSM_COMMIT: begin
                if (pass_end) begin
                    state_next = FSM_RESP;
                end
            end
            FSM_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    always_comb begin
        shift_en  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            FSM_SCAN, FSM_COMMIT: shift_en = 1'b1;
            FSM_DIV_LOAD:         div_start = 1'b1;
            FSM_RESP:             out_load = !m_valid_reg || m_ready;
            default: begin
                shift_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= FSM_IDLE;
            id_reg           <= IDW'(MAX_ENTRIES - 1);
            fc_reg           <= '0;
            target_red_reg   <= DEF_TARGET_RED;
            target_green_reg <= DEF_TARGET_GREEN;
            spread_reg       <= DEF_SPREAD;
            radius_sq_reg    <= DEF_RADIUS_SQ;
            max_age_reg      <= DEF_MAX_AGE;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (shift_en) begin
                id_reg <= pass_end ? IDW'(MAX_ENTRIES - 1) : id_reg - 1'b1;
            end
            if (accept && s_command == CMD_TICK) begin
                fc_reg <= fc_reg + 1'b1;
            end else if (accept && s_command == CMD_CLEAR) begin
                fc_reg <= '0;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TARGET_RED:   target_red_reg   <= cfg_data[7:0];
                    CFG_TARGET_GREEN: target_green_reg <= cfg_data[7:0];
                    CFG_SPREAD:       spread_reg       <= cfg_data[6:0];
                    CFG_RADIUS_SQ:    radius_sq_reg    <= cfg_data[25:0];
                    CFG_MAX_AGE:      max_age_reg      <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg         <= s_command;
            x_reg          <= CB'(s_pos_x);
            y_reg          <= CB'(s_pos_y);
            removed_reg    <= '0;
            match_reg      <= 1'b0;
            free_reg       <= 1'b0;
            res_slot_reg   <= '0;
            res_cx_reg     <= '0;
            res_cy_reg     <= '0;
            res_status_reg <= (s_command == CMD_PIXEL) ? STAT_REJECT : STAT_DONE;
        end
        if (state_reg == FSM_SCAN) begin
            if (rem_inc) begin
                removed_reg <= removed_reg + 1'b1;
            end
            if (op_reg == CMD_PIXEL) begin
                if (head_v && near) begin
                    match_reg    <= 1'b1;
                    match_id_reg <= id_reg;
                    match_e_reg  <= head_e;
                end
                if (!head_v) begin
                    free_reg    <= 1'b1;
                    free_id_reg <= id_reg;
                end
            end
        end
        if (state_reg == FSM_DECIDE && op_reg == CMD_PIXEL) begin
            if (match_reg) begin
                res_status_reg <= STAT_JOIN;
                res_slot_reg   <= match_id_reg;
            end else if (free_reg) begin
                res_status_reg <= STAT_NEW;
                res_slot_reg   <= free_id_reg;
                res_cx_reg     <= x_reg;
                res_cy_reg     <= y_reg;
            end else begin
                res_status_reg <= STAT_DROP;
            end
        end
        if (state_reg == FSM_MUL) begin
            prod_x_reg <= (CB+NB)'(match_e_reg.cx) * (CB+NB)'(match_e_reg.n);
            prod_y_reg <= (CB+NB)'(match_e_reg.cy) * (CB+NB)'(match_e_reg.n);
        end
        if (state_reg == FSM_DIV_WAIT && !div_busy_x) begin
            res_cx_reg <= qx;
            res_cy_reg <= qy;
        end
        if (out_load) begin
            m_status_reg  <= res_status_reg;
            m_slot_reg    <= 6'(res_slot_reg);
            m_cx_reg      <= 12'(res_cx_reg);
            m_cy_reg      <= 12'(res_cy_reg);
            m_removed_reg <= 7'(removed_reg);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_slot         = m_slot_reg;
    assign m_centre_x_out = m_cx_reg;
    assign m_centre_y_out = m_cy_reg;
    assign m_removed      = m_removed_reg;

    a_div_only_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy_x |-> state_reg == FSM_DIV_WAIT)
        else $error("divider busy outside wait state");

    a_div_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy_x == div_busy_y)
        else $error("dividers out of step");

    a_chain_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == FSM_IDLE |-> id_reg == IDW'(MAX_ENTRIES - 1))
        else $error("slot chain not aligned when idle");

    a_commit_to_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == FSM_COMMIT && pass_end |=> state_reg == FSM_RESP)
        else $error("commit pass did not end in response");

endmodule

@@ tb/color_blob_centroid_tracker_core_tb.sv @@
// Testbench for the blob centroid tracker: directed table plus random pixels and commands.
`timescale 1ns / 1ps
module color_blob_centroid_tracker_core_tb;
    import cbct_pkg::*;

    localparam int NSLOT = 64;
    localparam int IDLE_WATCH = 20000;
    localparam logic [1:0] CMD_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
    } pixel_beat_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot;
        logic [11:0] cx;
        logic [11:0] cy;
        logic [6:0]  removed;
    } track_result_t;

    typedef struct packed {
        pixel_beat_t   beat;
        logic          fixed;
        track_result_t res;
    } table_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = '0;
    logic [7:0]  s_red = '0;
    logic [7:0]  s_green = '0;
    logic [11:0] s_pos_x = '0;
    logic [11:0] s_pos_y = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [5:0]  m_slot;
    logic [11:0] m_centre_x_out;
    logic [11:0] m_centre_y_out;
    logic [6:0]  m_removed;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    always #2 aclk = ~aclk;

    color_blob_centroid_tracker_core u_dut (.*);

    // tracker shadow
    logic [7:0]  trk_red, trk_green;
    logic [6:0]  trk_spread;
    logic [25:0] trk_radius;
    logic [31:0] trk_age;
    logic        blob_live [NSLOT];
    logic [11:0] blob_x [NSLOT];
    logic [11:0] blob_y [NSLOT];
    logic [23:0] blob_n [NSLOT];
    logic [31:0] blob_birth [NSLOT];
    logic [31:0] frame_no;

    track_result_t pending_results[$];
    track_result_t fixed_results[$];
    logic          fixed_known[$];
    int errors = 0;
    int n_results = 0;
    int n_beats = 0;
    int idle_cycles = 0;
    int s_idle_pct = 0;
    int m_idle_pct = 0;
    bit timed_out = 0;

    task automatic tracker_reset();
        trk_red = DEF_TARGET_RED;
        trk_green = DEF_TARGET_GREEN;
        trk_spread = DEF_SPREAD;
        trk_radius = DEF_RADIUS_SQ;
        trk_age = DEF_MAX_AGE;
        frame_no = '0;
        for (int i = 0; i < NSLOT; i++) blob_live[i] = 1'b0;
    endtask

    task automatic tracker_config(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            CFG_TARGET_RED:   trk_red = val[7:0];
            CFG_TARGET_GREEN: trk_green = val[7:0];
            CFG_SPREAD:       trk_spread = val[6:0];
            CFG_RADIUS_SQ:    trk_radius = val[25:0];
            CFG_MAX_AGE:      trk_age = val;
            default: ;
        endcase
    endtask

    function automatic logic color_ok(input logic [7:0] lvl, input logic [7:0] tgt);
        int d;
        d = int'(lvl) - int'(tgt);
        return d >= -int'(trk_spread) && d <= int'(trk_spread);
    endfunction

    function automatic track_result_t tracker_step(input pixel_beat_t b);
        track_result_t r;
        longint dx, dy, n;
        r = '0;
        r.status = STAT_DONE;
        if (b.command == CMD_TICK) begin
            frame_no = frame_no + 1;
            for (int i = 0; i < NSLOT; i++)
                if (blob_live[i] && (frame_no - blob_birth[i]) > trk_age) begin
                    blob_live[i] = 1'b0;
                    r.removed++;
                end
            return r;
        end
        if (b.command == CMD_CLEAR) begin
            for (int i = 0; i < NSLOT; i++) begin
                if (blob_live[i]) r.removed++;
                blob_live[i] = 1'b0;
            end
            frame_no = '0;
            return r;
        end
        if (b.command == CMD_NONE) return r;
        if (!color_ok(b.red, trk_red) || !color_ok(b.green, trk_green)) begin
            r.status = STAT_REJECT;
            return r;
        end
        for (int i = 0; i < NSLOT; i++) begin
            if (!blob_live[i]) continue;
            dx = longint'(blob_x[i]) - longint'(b.pos_x);
            dy = longint'(blob_y[i]) - longint'(b.pos_y);
            if (dx * dx + dy * dy <= longint'(trk_radius)) begin
                n = blob_n[i];
                blob_x[i] = 12'((longint'(blob_x[i]) * n + b.pos_x) / (n + 1));
                blob_y[i] = 12'((longint'(blob_y[i]) * n + b.pos_y) / (n + 1));
                if (blob_n[i] != 24'hFFFFFF) blob_n[i]++;
                r.status = STAT_JOIN;
                r.slot = 6'(i);
                r.cx = blob_x[i];
                r.cy = blob_y[i];
                return r;
            end
        end
        for (int i = 0; i < NSLOT; i++)
            if (!blob_live[i]) begin
                blob_live[i] = 1'b1;
                blob_x[i] = b.pos_x;
                blob_y[i] = b.pos_y;
                blob_n[i] = 24'd1;
                blob_birth[i] = frame_no;
                r.status = STAT_NEW;
                r.slot = 6'(i);
                r.cx = b.pos_x;
                r.cy = b.pos_y;
                return r;
            end
        r.status = STAT_DROP;
        return r;
    endfunction

    // result side
    always @(posedge aclk) begin
        track_result_t got, want;
        logic known;
        track_result_t typed;
        if (aresetn) begin
            m_ready <= ($urandom_range(99) >= m_idle_pct);
            if (m_valid && m_ready) begin
                got = '{m_status, m_slot, m_centre_x_out, m_centre_y_out, m_removed};
                n_results++;
                if (pending_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result beat %p", got);
                end else begin
                    want = pending_results.pop_front();
                    typed = fixed_results.pop_front();
                    known = fixed_known.pop_front();
                    if (got !== want || (known && got !== typed)) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch at result %0d: expected %p typed %p got %p",
                                     n_results, want, typed, got);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (s_valid && s_ready) n_beats++;
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge aclk) begin
        if (idle_cycles >= IDLE_WATCH) begin
            timed_out = 1;
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_beat(input pixel_beat_t b, input logic fixed, input track_result_t t);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= b.command;
        s_red <= b.red;
        s_green <= b.green;
        s_pos_x <= b.pos_x;
        s_pos_y <= b.pos_y;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(tracker_step(b));
        fixed_results.push_back(t);
        fixed_known.push_back(fixed);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2 * NSLOT + 40) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tracker_config(idx, val);
        @(posedge aclk);
    endtask

    function automatic pixel_beat_t make_pixel(input logic [11:0] x, input logic [11:0] y);
        pixel_beat_t b;
        int sp;
        sp = trk_spread;
        b.command = CMD_PIXEL;
        b.red = 8'(int'(trk_red) + $signed($urandom_range(2 * sp)) - sp);
        b.green = 8'(int'(trk_green) + $signed($urandom_range(2 * sp)) - sp);
        if ($urandom_range(9) == 0) begin
            b.red = 8'($urandom);
            b.green = 8'($urandom);
        end
        b.pos_x = x;
        b.pos_y = y;
        return b;
    endfunction

    task automatic random_phase(input int count, input int clusters);
        pixel_beat_t b;
        logic [11:0] cx [8];
        int k;
        for (int i = 0; i < 8; i++) begin
            cx[i] = 12'($urandom);
        end
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(99);
            if (k < 3) b = '{CMD_TICK, 8'($urandom), 8'($urandom), 12'($urandom), 12'($urandom)};
            else if (k < 4) b = '{CMD_CLEAR, 8'($urandom), 8'($urandom), 12'($urandom),
                                  12'($urandom)};
            else if (k < 5) b = '{CMD_NONE, 8'($urandom), 8'($urandom), 12'($urandom),
                                  12'($urandom)};
            else if (k < 80) begin
                k = $urandom_range(clusters - 1);
                b = make_pixel(cx[k] + 12'($urandom_range(60)) - 12'd30,
                               cx[7 - k] + 12'($urandom_range(60)) - 12'd30);
            end else
                b = make_pixel(12'($urandom), 12'($urandom));
            send_beat(b, 1'b0, '0);
        end
    endtask

    table_row_t plan[$];

    initial begin
        track_result_t none;
        none = '0;
        tracker_reset();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        s_idle_pct = 9;
        m_idle_pct = 77;

        // reset values, extremes, every command
        plan.push_back('{'{CMD_TICK, 8'd0, 8'd0, 12'd0, 12'd0}, 1'b1,
                         '{STAT_DONE, 6'd0, 12'd0, 12'd0, 7'd0}});
        plan.push_back('{'{CMD_PIXEL, 8'd0, 8'd0, 12'd0, 12'd0}, 1'b1,
                         '{STAT_REJECT, 6'd0, 12'd0, 12'd0, 7'd0}});
        plan.push_back('{'{CMD_PIXEL, 8'd255, 8'd255, 12'hFFF, 12'hFFF}, 1'b1,
                         '{STAT_REJECT, 6'd0, 12'd0, 12'd0, 7'd0}});
        plan.push_back('{'{CMD_PIXEL, 8'd210, 8'd229, 12'hFFF, 12'hFFF}, 1'b1,
                         '{STAT_NEW, 6'd0, 12'hFFF, 12'hFFF, 7'd0}});
        plan.push_back('{'{CMD_PIXEL, 8'd195, 8'd214, 12'hFFF, 12'hFC0}, 1'b0, none});
        plan.push_back('{'{CMD_PIXEL, 8'd225, 8'd244, 12'd0, 12'd0}, 1'b1,
                         '{STAT_NEW, 6'd2, 12'd0, 12'd0, 7'd0}});
        plan.push_back('{'{CMD_PIXEL, 8'd194, 8'd229, 12'd5, 12'd5}, 1'b1,
                         '{STAT_REJECT, 6'd0, 12'd0, 12'd0, 7'd0}});
        plan.push_back('{'{CMD_PIXEL, 8'd210, 8'd245, 12'd5, 12'd5}, 1'b1,
                         '{STAT_REJECT, 6'd0, 12'd0, 12'd0, 7'd0}});
        plan.push_back('{'{CMD_PIXEL, 8'd210, 8'd229, 12'd20, 12'd30}, 1'b0, none});
        plan.push_back('{'{CMD_PIXEL, 8'd210, 8'd229, 12'd2048, 12'd1024}, 1'b0, none});
        plan.push_back('{'{CMD_NONE, 8'hFF, 8'hFF, 12'hFFF, 12'hFFF}, 1'b1,
                         '{STAT_DONE, 6'd0, 12'd0, 12'd0, 7'd0}});
        plan.push_back('{'{CMD_CLEAR, 8'd0, 8'd0, 12'd0, 12'd0}, 1'b0, none});
        plan.push_back('{'{CMD_CLEAR, 8'd0, 8'd0, 12'd0, 12'd0}, 1'b1,
                         '{STAT_DONE, 6'd0, 12'd0, 12'd0, 7'd0}});
        foreach (plan[i]) send_beat(plan[i].beat, plan[i].fixed, plan[i].res);
        drain();

        // table full, then aging with max_age zero
        write_reg(CFG_RADIUS_SQ, 32'd0);
        for (int i = 0; i < NSLOT + 2; i++)
            send_beat('{CMD_PIXEL, 8'd210, 8'd229, 12'(i * 50), 12'(i)}, 1'b0, none);
        send_beat('{CMD_PIXEL, 8'd210, 8'd229, 12'd0, 12'd0}, 1'b0, none);
        drain();
        write_reg(CFG_MAX_AGE, 32'd0);
        send_beat('{CMD_TICK, 8'd0, 8'd0, 12'd0, 12'd0}, 1'b1,
                  '{STAT_DONE, 6'd0, 12'd0, 12'd0, 7'd64});
        drain();

        // max_age at top: entries never age out
        write_reg(CFG_MAX_AGE, 32'hFFFF_FFFF);
        write_reg(CFG_RADIUS_SQ, 32'h3FF_FFFF);
        write_reg(CFG_SPREAD, 32'd100);
        write_reg(CFG_TARGET_RED, 32'd0);
        write_reg(CFG_TARGET_GREEN, 32'd255);
        random_phase(350, 2);
        drain();

        s_idle_pct = 77;
        m_idle_pct = 9;
        write_reg(CFG_SPREAD, 32'd0);
        write_reg(CFG_TARGET_RED, 32'd255);
        write_reg(CFG_TARGET_GREEN, 32'd0);
        write_reg(CFG_RADIUS_SQ, 32'd400);
        write_reg(CFG_MAX_AGE, 32'd3);
        random_phase(400, 8);
        drain();

        s_idle_pct = 0;
        m_idle_pct = 0;
        write_reg(CFG_SPREAD, 32'd40);
        write_reg(CFG_TARGET_RED, 32'd128);
        write_reg(CFG_TARGET_GREEN, 32'd77);
        write_reg(CFG_RADIUS_SQ, 32'd2500);
        write_reg(CFG_MAX_AGE, 32'd10);
        random_phase(450, 6);
        drain();
        write_reg(CFG_SPREAD, 32'd15);
        write_reg(CFG_RADIUS_SQ, 32'd33554432);
        write_reg(CFG_MAX_AGE, 32'd300000);
        random_phase(500, 4);
        drain();

        $display("covered %0d input beats and %0d result beats", n_beats, n_results);
        $display("incl. full table, aging, clears, idle command, all register extremes");
        if (errors == 0 && pending_results.size() == 0 && !timed_out) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
